@@ rtl/core/pst_pkg.sv @@
package pst_pkg;

  // Coordinate width; every datapath width below follows from it.
  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned DIFF_W     = COORD_BITS + 1;
  localparam int unsigned PROD_W     = 2 * DIFF_W;
  localparam int unsigned SQ_W       = 2 * COORD_BITS;
  localparam int unsigned ELL_W      = 2 * SQ_W + 3;
  localparam int unsigned STAGES     = 5;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic        [SQ_W-1:0]       sq_t;
  typedef logic        [2*SQ_W-1:0]     quad_t;

  typedef enum logic [1:0] {
    KIND_RECT    = 2'd0,
    KIND_CIRCLE  = 2'd1,
    KIND_TRI     = 2'd2,
    KIND_ELLIPSE = 2'd3
  } kind_e;

  // Per-stage occupancy and load enables, stage 0 at bit 0.
  typedef struct packed {
    logic [STAGES-1:0] vld;
    logic [STAGES-1:0] ld;
  } pipe_ctl_t;

  // Operands for the four shared multipliers.
  typedef struct packed {
    kind_e kind;
    logic  hit;
    logic  flat;
    diff_t a0;
    diff_t b0;
    diff_t a1;
    diff_t b1;
    diff_t a2;
    diff_t b2;
    diff_t a3;
    diff_t b3;
  } mul_op_t;

  typedef struct packed {
    kind_e kind;
    logic  hit;
    logic  flat;
    prod_t p0;
    prod_t p1;
    prod_t p2;
    prod_t p3;
  } prod_set_t;

  function automatic diff_t sext(input coord_t v);
    return {v[COORD_BITS-1], v};
  endfunction

  function automatic diff_t mag_d(input diff_t v);
    return v[DIFF_W-1] ? -v : v;
  endfunction

endpackage

@@ rtl/core/pst_prep.sv @@
module pst_prep (
  input  logic              clk_i,
  input  pst_pkg::pipe_ctl_t ctl_i,
  input  logic [1:0]        kind_i,
  input  pst_pkg::coord_t   point_x_i,
  input  pst_pkg::coord_t   point_y_i,
  input  pst_pkg::coord_t   start_x_i,
  input  pst_pkg::coord_t   start_y_i,
  input  pst_pkg::coord_t   end_x_i,
  input  pst_pkg::coord_t   end_y_i,
  output pst_pkg::mul_op_t  op_o
);

  typedef struct packed {
    pst_pkg::kind_e  kind;
    logic            rect_hit;
    pst_pkg::coord_t px;
    pst_pkg::coord_t py;
    pst_pkg::coord_t cx;
    pst_pkg::coord_t cy;
    pst_pkg::diff_t  dpx_s;
    pst_pkg::diff_t  dpy_s;
    pst_pkg::diff_t  dpy_e;
    pst_pkg::diff_t  rx;
    pst_pkg::diff_t  ry;
  } s1_t;

  s1_t              s1_d, s1_q;
  pst_pkg::mul_op_t s2_d, s2_q;

  pst_pkg::coord_t x_lo, x_hi, y_lo, y_hi;
  pst_pkg::diff_t  sum_x, sum_y, adj_x, adj_y;
  pst_pkg::diff_t  dxe, dye, mx, my, mw, mh;

  // Stage 1: differences, bounding box, ellipse center (truncated toward zero).
  always_comb begin
    x_lo  = (start_x_i < end_x_i) ? start_x_i : end_x_i;
    x_hi  = (start_x_i < end_x_i) ? end_x_i : start_x_i;
    y_lo  = (start_y_i < end_y_i) ? start_y_i : end_y_i;
    y_hi  = (start_y_i < end_y_i) ? end_y_i : start_y_i;
    sum_x = pst_pkg::sext(start_x_i) + pst_pkg::sext(end_x_i);
    sum_y = pst_pkg::sext(start_y_i) + pst_pkg::sext(end_y_i);
    adj_x = sum_x + pst_pkg::diff_t'(sum_x[pst_pkg::DIFF_W-1]);
    adj_y = sum_y + pst_pkg::diff_t'(sum_y[pst_pkg::DIFF_W-1]);

    s1_d.kind     = pst_pkg::kind_e'(kind_i);
    s1_d.rect_hit = (point_x_i >= x_lo) && (point_x_i <= x_hi) &&
                    (point_y_i >= y_lo) && (point_y_i <= y_hi);
    s1_d.px       = point_x_i;
    s1_d.py       = point_y_i;
    s1_d.cx       = adj_x[pst_pkg::DIFF_W-1:1];
    s1_d.cy       = adj_y[pst_pkg::DIFF_W-1:1];
    s1_d.dpx_s    = pst_pkg::sext(point_x_i) - pst_pkg::sext(start_x_i);
    s1_d.dpy_s    = pst_pkg::sext(point_y_i) - pst_pkg::sext(start_y_i);
    s1_d.dpy_e    = pst_pkg::sext(point_y_i) - pst_pkg::sext(end_y_i);
    s1_d.rx       = pst_pkg::sext(end_x_i) - pst_pkg::sext(start_x_i);
    s1_d.ry       = pst_pkg::sext(end_y_i) - pst_pkg::sext(start_y_i);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[0]) begin
      s1_q <= s1_d;
    end
  end

  // Stage 2: steer the operands of the shared multipliers by shape kind.
  always_comb begin
    dxe = pst_pkg::sext(s1_q.px) - pst_pkg::sext(s1_q.cx);
    dye = pst_pkg::sext(s1_q.py) - pst_pkg::sext(s1_q.cy);
    mx  = pst_pkg::mag_d(dxe);
    my  = pst_pkg::mag_d(dye);
    mw  = pst_pkg::mag_d(s1_q.rx);
    mh  = pst_pkg::mag_d(s1_q.ry);

    s2_d.kind = s1_q.kind;
    s2_d.hit  = s1_q.rect_hit;
    s2_d.flat = (s1_q.rx == '0) || (s1_q.ry == '0);
    s2_d.a0   = '0;
    s2_d.b0   = '0;
    s2_d.a1   = '0;
    s2_d.b1   = '0;
    s2_d.a2   = '0;
    s2_d.b2   = '0;
    s2_d.a3   = '0;
    s2_d.b3   = '0;
    case (s1_q.kind)
      pst_pkg::KIND_CIRCLE: begin
        s2_d.a0 = s1_q.dpx_s;
        s2_d.b0 = s1_q.dpx_s;
        s2_d.a1 = s1_q.dpy_s;
        s2_d.b1 = s1_q.dpy_s;
        s2_d.a2 = s1_q.rx;
        s2_d.b2 = s1_q.rx;
        s2_d.a3 = s1_q.ry;
        s2_d.b3 = s1_q.ry;
      end
      pst_pkg::KIND_TRI: begin
        s2_d.a0 = s1_q.rx;
        s2_d.b0 = s1_q.dpy_s;
        s2_d.a1 = s1_q.ry;
        s2_d.b1 = s1_q.dpx_s;
        s2_d.a2 = s1_q.rx;
        s2_d.b2 = s1_q.dpy_e;
        s2_d.a3 = s1_q.rx;
        s2_d.b3 = s1_q.ry;
      end
      pst_pkg::KIND_ELLIPSE: begin
        s2_d.a0 = mx;
        s2_d.b0 = mx;
        s2_d.a1 = my;
        s2_d.b1 = my;
        s2_d.a2 = mw;
        s2_d.b2 = mw;
        s2_d.a3 = mh;
        s2_d.b3 = mh;
      end
      default: begin
        s2_d.a0 = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[1]) begin
      s2_q <= s2_d;
    end
  end

  assign op_o = s2_q;

endmodule

@@ rtl/core/pst_mul.sv @@
module pst_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pst_pkg::pipe_ctl_t  ctl_i,
  input  pst_pkg::mul_op_t    op_i,
  output pst_pkg::prod_set_t  prod_o
);

  pst_pkg::prod_set_t s3_d, s3_q;

  always_comb begin
    s3_d.kind = op_i.kind;
    s3_d.hit  = op_i.hit;
    s3_d.flat = op_i.flat;
    s3_d.p0   = op_i.a0 * op_i.b0;
    s3_d.p1   = op_i.a1 * op_i.b1;
    s3_d.p2   = op_i.a2 * op_i.b2;
    s3_d.p3   = op_i.a3 * op_i.b3;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[2]) begin
      s3_q <= s3_d;
    end
  end

  assign prod_o = s3_q;

  // Squared terms of circle and ellipse can never come out negative.
  a_square_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.vld[2] && (s3_q.kind == pst_pkg::KIND_CIRCLE ||
                     s3_q.kind == pst_pkg::KIND_ELLIPSE)
    |-> !s3_q.p0[pst_pkg::PROD_W-1] && !s3_q.p1[pst_pkg::PROD_W-1] &&
        !s3_q.p2[pst_pkg::PROD_W-1] && !s3_q.p3[pst_pkg::PROD_W-1])
    else $error("negative square in multiplier stage");

endmodule

@@ rtl/core/pst_eval.sv @@
module pst_eval (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pst_pkg::pipe_ctl_t ctl_i,
  input  pst_pkg::prod_set_t prod_i,
  output logic               inside_o
);

  typedef struct packed {
    pst_pkg::kind_e kind;
    logic           hit;
    logic           flat;
    pst_pkg::quad_t m0;
    pst_pkg::quad_t m1;
    pst_pkg::quad_t m2;
  } s4_t;

  s4_t s4_d, s4_q;
  logic res_d, res_q;

  logic signed [pst_pkg::PROD_W:0] cir_l, cir_r, tri_d;
  logic [pst_pkg::PROD_W:0]        t1;
  logic [pst_pkg::PROD_W-1:0]      t2, t3, tot;
  logic [pst_pkg::PROD_W+1:0]      tri_sum;
  pst_pkg::sq_t                    sq0, sq1, sq2, sq3;
  logic [pst_pkg::ELL_W-1:0]       ell_sum, ell_lhs, ell_rhs;

  // Stage 4: circle and triangle decisions; cross products for the ellipse.
  always_comb begin
    cir_l = {prod_i.p0[pst_pkg::PROD_W-1], prod_i.p0} +
            {prod_i.p1[pst_pkg::PROD_W-1], prod_i.p1};
    cir_r = {prod_i.p2[pst_pkg::PROD_W-1], prod_i.p2} +
            {prod_i.p3[pst_pkg::PROD_W-1], prod_i.p3};
    tri_d = {prod_i.p0[pst_pkg::PROD_W-1], prod_i.p0} -
            {prod_i.p1[pst_pkg::PROD_W-1], prod_i.p1};
    t1    = tri_d[pst_pkg::PROD_W] ? -tri_d : tri_d;
    t2    = prod_i.p1[pst_pkg::PROD_W-1] ? -prod_i.p1 : prod_i.p1;
    t3    = prod_i.p2[pst_pkg::PROD_W-1] ? -prod_i.p2 : prod_i.p2;
    tot   = prod_i.p3[pst_pkg::PROD_W-1] ? -prod_i.p3 : prod_i.p3;
    tri_sum = {1'b0, t1} + {2'b00, t2} + {2'b00, t3};

    sq0 = prod_i.p0[pst_pkg::SQ_W-1:0];
    sq1 = prod_i.p1[pst_pkg::SQ_W-1:0];
    sq2 = prod_i.p2[pst_pkg::SQ_W-1:0];
    sq3 = prod_i.p3[pst_pkg::SQ_W-1:0];

    s4_d.kind = prod_i.kind;
    s4_d.flat = prod_i.flat;
    s4_d.m0   = sq0 * sq3;
    s4_d.m1   = sq1 * sq2;
    s4_d.m2   = sq2 * sq3;
    case (prod_i.kind)
      pst_pkg::KIND_RECT:    s4_d.hit = prod_i.hit;
      pst_pkg::KIND_CIRCLE:  s4_d.hit = (cir_l <= cir_r);
      pst_pkg::KIND_TRI:     s4_d.hit = (tri_sum == {2'b00, tot});
      default:               s4_d.hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[3]) begin
      s4_q <= s4_d;
    end
  end

  // Stage 5: 4*(dx^2*H^2 + dy^2*W^2) against W^2*H^2.
  always_comb begin
    ell_sum = pst_pkg::ELL_W'(s4_q.m0) + pst_pkg::ELL_W'(s4_q.m1);
    ell_lhs = {ell_sum[pst_pkg::ELL_W-3:0], 2'b00};
    ell_rhs = pst_pkg::ELL_W'(s4_q.m2);
    if (s4_q.kind == pst_pkg::KIND_ELLIPSE) begin
      res_d = !s4_q.flat && (ell_lhs <= ell_rhs);
    end else begin
      res_d = s4_q.hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[4]) begin
      res_q <= res_d;
    end
  end

  assign inside_o = res_q;

  // A non-flat ellipse box always has a nonzero area product.
  a_ell_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.vld[3] && (s4_q.kind == pst_pkg::KIND_ELLIPSE) && !s4_q.flat
    |-> (s4_q.m2 != '0))
    else $error("ellipse area product is zero for a non-flat box");

endmodule

@@ rtl/core/point_in_shape_test.sv @@
// Channel   Direction  Handshake           Payload
// --------  ---------  ------------------  -------------------------------------------
// query     in         valid_i / stall_o   kind_i, point_{x,y}_i, start_{x,y}_i,
//                                          end_{x,y}_i
// result    out        valid_o / stall_i   inside_res_o
//
// One query per cycle is taken while stall_o is low. Each query passes through the five
// register stages in order: prepare, operand steer, shared 17x17 multipliers, cross
// products, compare.
// Reset clears only the stage valid bits; data registers load freely.
// A stalled output stage backs up only as far as the first empty stage, so bubbles
// are squeezed out and stall_o rises only when all five stages hold a query.
module point_in_shape_test (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            stall_o,
  input  logic [1:0]      kind_i,
  input  pst_pkg::coord_t point_x_i,
  input  pst_pkg::coord_t point_y_i,
  input  pst_pkg::coord_t start_x_i,
  input  pst_pkg::coord_t start_y_i,
  input  pst_pkg::coord_t end_x_i,
  input  pst_pkg::coord_t end_y_i,
  output logic            valid_o,
  input  logic            stall_i,
  output logic            inside_res_o
);

  logic [pst_pkg::STAGES-1:0] v_d, v_q;
  logic [pst_pkg::STAGES-1:0] rdy;
  pst_pkg::pipe_ctl_t         ctl;
  pst_pkg::mul_op_t           op;
  pst_pkg::prod_set_t         prod;

  // A stage may load when it is empty or the stage after it moves on.
  always_comb begin
    rdy[pst_pkg::STAGES-1] = !v_q[pst_pkg::STAGES-1] || !stall_i;
    for (int i = pst_pkg::STAGES - 2; i >= 0; i--) begin
      rdy[i] = !v_q[i] || rdy[i+1];
    end
    v_d[0] = rdy[0] ? valid_i : v_q[0];
    for (int i = 1; i < pst_pkg::STAGES; i++) begin
      v_d[i] = rdy[i] ? v_q[i-1] : v_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign ctl.vld = v_q;
  assign ctl.ld  = rdy;
  assign stall_o = !rdy[0];
  assign valid_o = v_q[pst_pkg::STAGES-1];

  // Stages 1-2: differences, bounding box, center; operand steering.
  pst_prep u_prep (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .kind_i    (kind_i),
    .point_x_i (point_x_i),
    .point_y_i (point_y_i),
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .op_o      (op)
  );

  // Stage 3: four shared signed multipliers.
  pst_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .op_i   (op),
    .prod_o (prod)
  );

  // Stages 4-5: per-shape decisions and the ellipse inequality.
  pst_eval u_eval (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .prod_i   (prod),
    .inside_o (inside_res_o)
  );

  // Input backs up only with every stage occupied.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (&v_q))
    else $error("input stalled with an empty pipeline stage");

  // An empty output stage means the whole pipe can advance.
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> !stall_o)
    else $error("input stalled while output stage is empty");

  // With no output stall, a transfer in is not lost and shows up at the output.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(valid_i && !stall_o, 5) &&
    $past(rst_ni, 1) && $past(rst_ni, 2) && $past(rst_ni, 3) &&
    $past(rst_ni, 4) && $past(rst_ni, 5) &&
    !$past(stall_i, 1) && !$past(stall_i, 2) &&
    !$past(stall_i, 3) && !$past(stall_i, 4)
    |-> valid_o)
    else $error("query lost or delayed in an unstalled pipeline");

endmodule
